### rtl/cpss_pkg.sv
// Shared widths, types and constants for the closest-point-on-segment-set block.
// No dependencies; the multiplier, divider and top-level files import this package.
`timescale 1ns / 1ps
package cpss_pkg;

  localparam int MaxSegments = 256;
  localparam int SegAw       = $clog2(MaxSegments);
  localparam int CntW        = $clog2(MaxSegments + 1);
  localparam int SegW        = 128;
  localparam int MulW        = 34;
  localparam int ProdW       = 2 * MulW;
  localparam int NumW        = 98;
  localparam int DenW        = 66;
  localparam int QuoW        = 33;

  localparam logic FuncLoad  = 1'b0;
  localparam logic FuncQuery = 1'b1;

  typedef logic signed [31:0]      coord_t;
  typedef logic signed [32:0]      diff_t;
  typedef logic signed [MulW-1:0]  mul_op_t;
  typedef logic signed [ProdW-1:0] prod_t;

  // Request from the sequencer to the divider.
  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } div_req_t;

  // Status returned by the divider.
  typedef struct packed {
    logic            done;
    logic [QuoW-1:0] quo;
  } div_rsp_t;

endpackage

### rtl/cpss_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
module cpss_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/cpss_mul.sv
// Shared signed multiplier with a registered product.
// Depends on cpss_pkg.
`timescale 1ns / 1ps
module cpss_mul (
  input  logic             clk_i,
  input  cpss_pkg::mul_op_t a_i,
  input  cpss_pkg::mul_op_t b_i,
  output cpss_pkg::prod_t   p_o
);
  import cpss_pkg::*;

  always_ff @(posedge clk_i) begin
    p_o <= a_i * b_i;
  end

endmodule

### rtl/cpss_div.sv
// Restoring divider, one quotient bit per cycle, for the clamped projection.
// Depends on cpss_pkg. The quotient is known to stay below 2^33.
`timescale 1ns / 1ps
module cpss_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cpss_pkg::div_req_t  req_i,
  output cpss_pkg::div_rsp_t  rsp_o
);
  import cpss_pkg::*;

  logic [DenW-1:0] rem_q, rem_d;
  logic [QuoW-1:0] bits_q, bits_d;
  logic [QuoW-1:0] quo_q, quo_d;
  logic [DenW-1:0] den_q;
  logic [5:0]      cnt_q, cnt_d;
  logic            done_q, done_d;
  logic [DenW:0]   trial;

  always_comb begin
    trial  = {rem_q, bits_q[QuoW-1]};
    rem_d  = rem_q;
    bits_d = bits_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (cnt_q != 6'd0) begin
      bits_d = {bits_q[QuoW-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = DenW'(trial - {1'b0, den_q});
        quo_d = {quo_q[QuoW-2:0], 1'b1};
      end else begin
        rem_d = trial[DenW-1:0];
        quo_d = {quo_q[QuoW-2:0], 1'b0};
      end
      cnt_d  = cnt_q - 6'd1;
      done_d = (cnt_q == 6'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
      cnt_q  <= req_i.start ? 6'(QuoW) : cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= DenW'(req_i.num[NumW-1:QuoW]);
      bits_q <= req_i.num[QuoW-1:0];
      den_q  <= req_i.den;
      quo_q  <= '0;
    end else begin
      rem_q  <= rem_d;
      bits_q <= bits_d;
      quo_q  <= quo_d;
    end
  end

  assign rsp_o = '{done: done_q, quo: quo_q};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(cnt_q) == 6'd1)
    else $error("divider finished without its last step");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> cnt_q == 6'(QuoW))
    else $error("divider did not load its step count");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("divider done held longer than one cycle");

endmodule

### rtl/closest_point_on_segment_set_top.sv
// Closest point on a set of segments: a load word writes a table row and gives no result.
// A query word scans segments_in_use slots (at most 256), each clamped to its first end, to its
// second end, or solved inside (ten passes through the shared 34x34 multiplier and two
// divisions). done_o then strobes once; an empty table answers without a scan.
// busy_o is high for the scan, and the next word is taken at the edge ending done_o.
// Reset clears the count register, outputs and sequencer; the table is undefined until loaded.
`timescale 1ns / 1ps
module closest_point_on_segment_set_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic                 func_i,
  input  logic [7:0]           seg_index_i,
  input  logic signed [31:0]   start_x_i,
  input  logic signed [31:0]   start_y_i,
  input  logic signed [31:0]   end_x_i,
  input  logic signed [31:0]   end_y_i,
  input  logic signed [31:0]   probe_x_i,
  input  logic signed [31:0]   probe_y_i,
  output logic                 done_o,
  output logic signed [31:0]   closest_x_o,
  output logic signed [31:0]   closest_y_o,
  output logic                 table_empty_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import cpss_pkg::*;

  typedef enum logic [4:0] {
    StIdle, StRead, StLoad, StC1a, StC1b, StC1c, StC2a, StC2b, StCmp,
    StSa, StSb, StSc, StDiv, StDa, StDb, StDc
  } state_e;

  state_e state_q;

  // Configuration register. Only byte address 0 holds a register.
  logic [CntW-1:0] siu_q;
  logic [CntW-1:0] nseg;
  assign pready = 1'b1;
  assign prdata = (paddr == 3'd0) ? 32'(siu_q) : 32'd0;
  assign nseg   = (siu_q > CntW'(MaxSegments)) ? CntW'(MaxSegments) : siu_q;

  logic accept;
  assign accept = start_i && !busy_o;

  // Segment table: one 128-bit row per slot, {x0, y0, x1, y1}.
  logic [SegW-1:0]  rdata;
  logic [SegAw-1:0] raddr;
  logic [CntW-1:0]  idx_q;
  logic             we;
  assign we    = accept && (func_i == FuncLoad) && (32'(seg_index_i) < MaxSegments);
  assign raddr = idx_q[SegAw-1:0];

  cpss_ram #(.Width(SegW), .Depth(MaxSegments)) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (seg_index_i[SegAw-1:0]),
    .wdata_i ({start_x_i, start_y_i, end_x_i, end_y_i}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Working registers for one segment.
  coord_t px_q, py_q, x0_q, y0_q, x1_q, y1_q, cx_q, cy_q;
  diff_t  vx_q, vy_q, wx_q, wy_q;
  prod_t  acc_q, c1_q, c2_q;
  logic [DenW-1:0] best_q;
  logic            found_q;
  logic            axis_q;

  // Shared multiplier; its product appears in the cycle after the operands.
  mul_op_t ma, mb;
  prod_t   prod;
  cpss_mul u_mul (.clk_i(clk_i), .a_i(ma), .b_i(mb), .p_o(prod));

  // Magnitude and sign of the coordinate of V being scaled.
  diff_t       vsel;
  logic [32:0] vmag;
  diff_t       dx, dy;
  assign vsel = axis_q ? vy_q : vx_q;
  assign vmag = vsel[32] ? 33'(-vsel) : 33'(vsel);
  assign dx   = diff_t'(px_q) - diff_t'(cx_q);
  assign dy   = diff_t'(py_q) - diff_t'(cy_q);

  always_comb begin
    ma = '0;
    mb = '0;
    case (state_q)
      StC1a: begin ma = mul_op_t'(vx_q); mb = mul_op_t'(wx_q); end
      StC1b: begin ma = mul_op_t'(vy_q); mb = mul_op_t'(wy_q); end
      StC1c: begin ma = mul_op_t'(vx_q); mb = mul_op_t'(vx_q); end
      StC2a: begin ma = mul_op_t'(vy_q); mb = mul_op_t'(vy_q); end
      StSa:  begin ma = {1'b0, c1_q[32:0]};  mb = {1'b0, vmag}; end
      StSb:  begin ma = {2'b0, c1_q[64:33]}; mb = {1'b0, vmag}; end
      StDa:  begin ma = mul_op_t'(dx); mb = mul_op_t'(dx); end
      StDb:  begin ma = mul_op_t'(dy); mb = mul_op_t'(dy); end
      default: ;
    endcase
  end

  // Divider request: numerator is c1 * |v|, assembled from two partial products.
  div_req_t dreq;
  div_rsp_t drsp;
  assign dreq = '{start: (state_q == StSc),
                  num:   {30'b0, acc_q} + {prod[64:0], 33'b0},
                  den:   c2_q[DenW-1:0]};

  cpss_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq), .rsp_o(drsp));

  // Signed scaled offset and the resulting coordinate.
  diff_t  qs;
  coord_t base, cnew;
  prod_t  sq_dist;
  assign qs      = vsel[32] ? -diff_t'(drsp.quo[31:0]) : diff_t'(drsp.quo[31:0]);
  assign base    = axis_q ? y0_q : x0_q;
  assign cnew    = coord_t'(diff_t'(base) + qs);
  assign sq_dist = acc_q + prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      siu_q         <= '0;
      busy_o        <= 1'b0;
      done_o        <= 1'b0;
      table_empty_o <= 1'b0;
      closest_x_o   <= '0;
      closest_y_o   <= '0;
      cx_q          <= '0;
      cy_q          <= '0;
      best_q        <= '0;
      idx_q         <= '0;
      found_q       <= 1'b0;
      axis_q        <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (psel && penable && pwrite && pready && (paddr == 3'd0)) begin
        siu_q <= pwdata[CntW-1:0];
      end
      unique case (state_q)
        StIdle: begin
          if (accept && (func_i == FuncQuery)) begin
            idx_q   <= '0;
            found_q <= 1'b0;
            if (nseg == '0) begin
              done_o        <= 1'b1;
              table_empty_o <= 1'b1;
              closest_x_o   <= '0;
              closest_y_o   <= '0;
            end else begin
              busy_o  <= 1'b1;
              state_q <= StRead;
            end
          end
        end
        StRead: state_q <= StLoad;
        StLoad: state_q <= StC1a;
        StC1a:  state_q <= StC1b;
        StC1b:  state_q <= StC1c;
        StC1c:  state_q <= StC2a;
        StC2a: begin
          if (c1_q[ProdW-1] || (c1_q == '0)) begin
            cx_q    <= x0_q;
            cy_q    <= y0_q;
            state_q <= StDa;
          end else begin
            state_q <= StC2b;
          end
        end
        StC2b: state_q <= StCmp;
        StCmp: begin
          if (c1_q >= c2_q) begin
            cx_q    <= x1_q;
            cy_q    <= y1_q;
            state_q <= StDa;
          end else begin
            axis_q  <= 1'b0;
            state_q <= StSa;
          end
        end
        StSa: state_q <= StSb;
        StSb: state_q <= StSc;
        StSc: state_q <= StDiv;
        StDiv: begin
          if (drsp.done) begin
            if (axis_q) begin
              cy_q    <= cnew;
              state_q <= StDa;
            end else begin
              cx_q    <= cnew;
              axis_q  <= 1'b1;
              state_q <= StSa;
            end
          end
        end
        StDa: state_q <= StDb;
        StDb: state_q <= StDc;
        StDc: begin
          if (!found_q || (sq_dist[DenW-1:0] < best_q)) begin
            found_q     <= 1'b1;
            best_q      <= sq_dist[DenW-1:0];
            closest_x_o <= cx_q;
            closest_y_o <= cy_q;
          end
          if (idx_q + CntW'(1) == nseg) begin
            done_o        <= 1'b1;
            table_empty_o <= 1'b0;
            busy_o        <= 1'b0;
            state_q       <= StIdle;
          end else begin
            idx_q   <= idx_q + CntW'(1);
            state_q <= StRead;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Datapath registers; the accumulator captures the registered product of the shared multiplier.
  always_ff @(posedge clk_i) begin
    if (accept && (func_i == FuncQuery)) begin
      px_q <= probe_x_i;
      py_q <= probe_y_i;
    end
    if (state_q == StLoad) begin
      x0_q <= rdata[127:96];
      y0_q <= rdata[95:64];
      x1_q <= rdata[63:32];
      y1_q <= rdata[31:0];
      vx_q <= diff_t'(coord_t'(rdata[63:32])) - diff_t'(coord_t'(rdata[127:96]));
      vy_q <= diff_t'(coord_t'(rdata[31:0]))  - diff_t'(coord_t'(rdata[95:64]));
      wx_q <= diff_t'(px_q) - diff_t'(coord_t'(rdata[127:96]));
      wy_q <= diff_t'(py_q) - diff_t'(coord_t'(rdata[95:64]));
    end
    if (state_q == StC1b || state_q == StC2a || state_q == StSb || state_q == StDb) begin
      acc_q <= prod;
    end
    if (state_q == StC1c) begin
      c1_q <= acc_q + prod;
    end
    if (state_q == StC2b) begin
      c2_q <= acc_q + prod;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobed while a scan is still running");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && table_empty_o) |-> (closest_x_o == 0 && closest_y_o == 0))
    else $error("empty table result carries a nonzero point");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv && drsp.done) |-> (c1_q < c2_q && c1_q > 0))
    else $error("division used outside the interior of a segment");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> idx_q < nseg)
    else $error("scan index ran past the segment count");

endmodule
